/* rtl/sliding_window_receiver_macros.svh */
`ifndef SLIDING_WINDOW_RECEIVER_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_MACROS_SVH

// Both checks are sampled on clk and switched off while arst_n is low.

// A condition that must hold at every edge.
`define SWR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define SWR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/swr_pkg.sv */
package swr_pkg;

	localparam int unsigned REORDER_DEPTH_DEF = 32;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WIN_W  = 6;

	// Configuration port
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned REG_IDX_W  = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'b0;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd32;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	typedef struct packed {
		logic take_in;
		logic store;
		logic load_ack;
		logic load_first;
		logic load_drain;
	} swr_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic ok;
		logic behind;
		logic full;
		logic out_of_window;
		logic at_expected;
		logic out_free;
		logic slot_held;
	} swr_status_t;

endpackage

/* rtl/swr_if.sv */
interface swr_in_if;
	logic                       valid;
	logic                       ready;
	logic [swr_pkg::SEQ_W-1:0]  seq_num;
	logic [swr_pkg::BYTE_W-1:0] payload;
	logic                       packet_ok;

	modport source (output valid, seq_num, payload, packet_ok, input ready);
	modport sink (input valid, seq_num, payload, packet_ok, output ready);
endinterface

interface swr_out_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [swr_pkg::BYTE_W-1:0] out_byte;
	logic [swr_pkg::SEQ_W-1:0]  position;
	logic [swr_pkg::SEQ_W-1:0]  ack_next;
	logic [swr_pkg::WIN_W-1:0]  adv_window;
	logic                       last;

	modport source (output valid, kind, out_byte, position, ack_next, adv_window, last,
		input ready);
	modport sink (input valid, kind, out_byte, position, ack_next, adv_window, last,
		output ready);
endinterface

/* rtl/swr_ctrl.sv */
module swr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swr_pkg::swr_status_t status,
	output swr_pkg::swr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_ACK,
		ST_FIRST,
		ST_DRAIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.take_in = 1'b1;
				if (status.in_valid) begin
					state_d = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				// The order of these tests matters: a duplicate is answered even
				// when the buffer is full, and a full buffer even when the packet
				// lies outside the window.
				if (!status.ok) begin
					state_d = ST_IDLE;
				end else if (status.behind || status.full) begin
					state_d = ST_ACK;
				end else if (status.out_of_window) begin
					state_d = ST_IDLE;
				end else if (status.at_expected) begin
					state_d = ST_FIRST;
				end else begin
					cmd.store = 1'b1;
					state_d   = ST_ACK;
				end
			end
			ST_ACK: begin
				if (status.out_free) begin
					cmd.load_ack = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FIRST: begin
				if (status.out_free) begin
					cmd.load_first = 1'b1;
					state_d        = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.slot_held) begin
					state_d = ST_ACK;
				end else if (status.out_free) begin
					cmd.load_drain = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/swr_datapath.sv */
`include "sliding_window_receiver_macros.svh"

module swr_datapath #(
	parameter int unsigned REORDER_DEPTH = swr_pkg::REORDER_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	swr_in_if.sink                      pkt,
	swr_out_if.source                   res,
	input  logic [swr_pkg::WIN_W-1:0]   window_size,
	input  swr_pkg::swr_cmd_t           cmd,
	output swr_pkg::swr_status_t        status
);

	localparam int unsigned IDX_W = $clog2(REORDER_DEPTH);
	localparam int unsigned CNT_W = $clog2(REORDER_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REORDER_DEPTH - 1);
	localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(REORDER_DEPTH);
	localparam logic [swr_pkg::WIN_W-1:0] DEPTH_WIN = swr_pkg::WIN_W'(REORDER_DEPTH);

	// Captured packet
	logic [swr_pkg::SEQ_W-1:0]  seq_q;
	logic [swr_pkg::BYTE_W-1:0] payload_q;
	logic                       ok_q;

	// Receive state. Slot j lives at physical index (base_q + j) mod depth.
	logic [swr_pkg::SEQ_W-1:0]  delivered_q;
	logic [IDX_W-1:0]           base_q;
	logic [CNT_W-1:0]           held_q;
	logic [REORDER_DEPTH-1:0]   valid_q;
	logic [swr_pkg::BYTE_W-1:0] slot_mem [REORDER_DEPTH];
	logic [swr_pkg::BYTE_W-1:0] rdata_q;

	// Output register
	logic                       out_valid_q;
	logic                       kind_q;
	logic [swr_pkg::BYTE_W-1:0] out_byte_q;
	logic [swr_pkg::SEQ_W-1:0]  position_q;
	logic [swr_pkg::SEQ_W-1:0]  ack_next_q;
	logic [swr_pkg::WIN_W-1:0]  adv_q;
	logic                       last_q;

	logic [swr_pkg::SEQ_W-1:0]  expected;
	logic [swr_pkg::SEQ_W-1:0]  offset;
	logic [swr_pkg::WIN_W-1:0]  eff_win;
	logic [swr_pkg::WIN_W-1:0]  held_win;
	logic [swr_pkg::WIN_W-1:0]  adv_now;
	logic [IDX_W:0]             phys_sum;
	logic [IDX_W-1:0]           phys;
	logic [IDX_W-1:0]           base_inc;
	logic [IDX_W-1:0]           raddr;
	logic                       advance;
	logic                       store_en;
	logic                       load_any;

	assign expected = delivered_q + swr_pkg::SEQ_W'(1);
	assign offset   = seq_q - expected;

	always_comb begin
		if (window_size == '0) begin
			eff_win = swr_pkg::WIN_W'(1);
		end else if (window_size > DEPTH_WIN) begin
			eff_win = DEPTH_WIN;
		end else begin
			eff_win = window_size;
		end
	end

	assign held_win = swr_pkg::WIN_W'(held_q);
	assign adv_now  = (held_win >= eff_win) ? '0 : (eff_win - held_win);

	// The offset is below the window here, so one subtraction brings it in range.
	assign phys_sum = {1'b0, base_q} + {1'b0, offset[IDX_W-1:0]};
	assign phys     = (phys_sum >= DEPTH_EXT) ? IDX_W'(phys_sum - DEPTH_EXT)
		: phys_sum[IDX_W-1:0];
	assign base_inc = (base_q == LAST_IDX) ? '0 : (base_q + IDX_W'(1));

	assign advance  = cmd.load_first | cmd.load_drain;
	assign raddr    = advance ? base_inc : base_q;
	assign store_en = cmd.store & ~valid_q[phys];
	assign load_any = cmd.load_ack | advance;

	always_comb begin
		status.in_valid      = pkt.valid;
		status.ok            = ok_q;
		status.behind        = offset[swr_pkg::SEQ_W-1];
		status.full          = held_win >= eff_win;
		status.out_of_window = offset >= swr_pkg::SEQ_W'(eff_win);
		status.at_expected   = offset == '0;
		status.out_free      = ~out_valid_q | res.ready;
		status.slot_held     = valid_q[base_q];
	end

	assign pkt.ready      = cmd.take_in;
	assign res.valid      = out_valid_q;
	assign res.kind       = kind_q;
	assign res.out_byte   = out_byte_q;
	assign res.position   = position_q;
	assign res.ack_next   = ack_next_q;
	assign res.adv_window = adv_q;
	assign res.last       = last_q;

	always_ff @(posedge clk) begin
		if (cmd.take_in && pkt.valid) begin
			seq_q     <= pkt.seq_num;
			payload_q <= pkt.payload;
			ok_q      <= pkt.packet_ok;
		end
	end

	// The read port follows the window base, so rdata_q always holds slot 0.
	always_ff @(posedge clk) begin
		if (store_en) begin
			slot_mem[phys] <= payload_q;
		end
		rdata_q <= slot_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delivered_q <= '0;
			base_q      <= '0;
			held_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				delivered_q <= delivered_q + swr_pkg::SEQ_W'(1);
				base_q      <= base_inc;
			end
			if (store_en) begin
				valid_q[phys] <= 1'b1;
				held_q        <= held_q + CNT_W'(1);
			end else if (cmd.load_drain) begin
				valid_q[base_q] <= 1'b0;
				held_q          <= held_q - CNT_W'(1);
			end
			if (load_any) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_ack) begin
			kind_q     <= swr_pkg::KIND_ACK;
			out_byte_q <= '0;
			position_q <= '0;
			ack_next_q <= expected;
			adv_q      <= adv_now;
			last_q     <= 1'b1;
		end else if (advance) begin
			kind_q     <= swr_pkg::KIND_DATA;
			out_byte_q <= cmd.load_first ? payload_q : rdata_q;
			position_q <= delivered_q;
			ack_next_q <= '0;
			adv_q      <= '0;
			last_q     <= 1'b0;
		end
	end

	`SWR_ASSERT_ALWAYS(a_held_count, $countones(valid_q) == held_q, "held count out of step")
	`SWR_ASSERT_IMPLIES(a_idle_base_empty, cmd.take_in, !valid_q[base_q], "slot 0 held at idle")
	`SWR_ASSERT_IMPLIES(a_load_free, load_any, status.out_free, "result word overwritten")
	`SWR_ASSERT_IMPLIES(a_drain_held, cmd.load_drain, valid_q[base_q], "drained an empty slot")

endmodule

/* rtl/sliding_window_receiver.sv */
// Selective-repeat receive window.
// Packets arrive on pkt as words of sequence number, data byte and checksum flag;
// results leave on res, each word either a delivered byte with its stream
// position or an acknowledgement with the next expected number and the
// advertised window. The last word caused by a packet has last set.
// The window size register sits at byte address 0 of the APB port and may be
// written only while the block is idle; it resets to 32.
// One packet is worked on at a time. A packet is taken in the idle state, classified
// in the next, and its first result is loaded into the output register once that
// register is free. A packet that completes the in-order run delivers its own byte,
// then one byte per cycle while res takes them from the reorder memory, whose
// registered read port follows the window base (up to the reorder depth in all),
// then an acknowledgement. Other good packets give an acknowledgement alone, but
// out-of-window ones give none unless the buffer is full. Bad packets give none.
// When res stalls, the output register holds its word and the sequencer waits;
// a new packet may still be taken while the last word waits.
// Reset clears the expected number, the held count and all slot valid bits at
// once; no clearing pass is needed.
module sliding_window_receiver #(
	parameter int unsigned REORDER_DEPTH = swr_pkg::REORDER_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	swr_in_if.sink                             pkt,
	swr_out_if.source                          res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swr_pkg::PADDR_W-1:0]        paddr,
	input  logic [swr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [swr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	logic [swr_pkg::WIN_W-1:0]     window_q;
	logic [swr_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_window;
	swr_pkg::swr_cmd_t             cmd;
	swr_pkg::swr_status_t          status;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[swr_pkg::PADDR_W-1:2];
	assign wr_window = psel & penable & pwrite & pready & (reg_idx == swr_pkg::REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swr_pkg::WINDOW_RESET;
		end else if (wr_window) begin
			window_q <= pwdata[swr_pkg::WIN_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == swr_pkg::REG_WINDOW) begin
			prdata = swr_pkg::APB_DATA_W'(window_q);
		end else begin
			prdata = '0;
		end
	end

	swr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	swr_datapath #(
		.REORDER_DEPTH (REORDER_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt         (pkt),
		.res         (res),
		.window_size (window_q),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DEPTH         = swr_pkg::REORDER_DEPTH_DEF;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned LONG_HOLD     = 400;

	typedef enum int unsigned {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

	typedef struct packed {
		logic                       kind;
		logic [swr_pkg::BYTE_W-1:0] out_byte;
		logic [swr_pkg::SEQ_W-1:0]  position;
		logic [swr_pkg::SEQ_W-1:0]  ack_next;
		logic [swr_pkg::WIN_W-1:0]  adv_window;
		logic                       last;
	} rx_word_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [swr_pkg::PADDR_W-1:0]    paddr;
	logic [swr_pkg::APB_DATA_W-1:0] pwdata;
	logic [swr_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	swr_in_if  pkt ();
	swr_out_if res ();

	sliding_window_receiver DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Receive window as the testbench sees it.
	logic [swr_pkg::WIN_W-1:0]  win_reg;
	logic [swr_pkg::SEQ_W-1:0]  delivered;
	logic                       slot_vld [DEPTH];
	logic [swr_pkg::BYTE_W-1:0] slot_dat [DEPTH];
	rx_word_t                   due_words [$];

	int unsigned fail_count;
	int unsigned n_sent, n_counted, n_configs;
	int unsigned n_words, n_bytes, n_acks, longest_run;

	// Sender and receiver pacing.
	int unsigned burst_left, gap_max, burst_max;
	rx_mode_t    rx_mode;
	int unsigned hold_req, hold_left, rx_run;
	logic        rx_level;

	always #5 clk = ~clk;

	function automatic int unsigned live_window();
		if (win_reg == 0)
			return 1;
		if (win_reg > DEPTH)
			return DEPTH;
		return win_reg;
	endfunction

	function automatic int unsigned held_slots();
		int unsigned n = 0;
		foreach (slot_vld[i])
			if (slot_vld[i])
				n++;
		return n;
	endfunction

	function automatic logic [swr_pkg::WIN_W-1:0] free_window();
		int unsigned w;
		int unsigned h;
		w = live_window();
		h = held_slots();
		return (h >= w) ? '0 : swr_pkg::WIN_W'(w - h);
	endfunction

	function automatic void push_word(logic kind, logic [swr_pkg::BYTE_W-1:0] b,
			logic [swr_pkg::SEQ_W-1:0] pos, logic [swr_pkg::SEQ_W-1:0] nxt,
			logic [swr_pkg::WIN_W-1:0] adv, logic last);
		rx_word_t w;
		w.kind       = kind;
		w.out_byte   = b;
		w.position   = pos;
		w.ack_next   = nxt;
		w.adv_window = adv;
		w.last       = last;
		due_words.push_back(w);
	endfunction

	// Works out the words that one accepted packet causes and updates the window.
	function automatic void receive_packet(logic [swr_pkg::SEQ_W-1:0] seq,
			logic [swr_pkg::BYTE_W-1:0] data, logic ok);
		logic [swr_pkg::SEQ_W-1:0] nxt;
		logic [swr_pkg::SEQ_W-1:0] off;
		int unsigned               w;
		int unsigned               run;
		if (!ok)
			return;
		nxt = delivered + 1;
		off = seq - nxt;
		w   = live_window();
		if (off[swr_pkg::SEQ_W-1]) begin
			push_word(swr_pkg::KIND_ACK, '0, '0, nxt, free_window(), 1'b1);
		end else if (held_slots() >= w) begin
			// The full test comes after the duplicate test, before the window test.
			push_word(swr_pkg::KIND_ACK, '0, '0, nxt, '0, 1'b1);
		end else if (off >= w) begin
			return;
		end else if (off != 0) begin
			if (!slot_vld[off]) begin
				slot_vld[off] = 1'b1;
				slot_dat[off] = data;
			end
			push_word(swr_pkg::KIND_ACK, '0, '0, nxt, free_window(), 1'b1);
		end else begin
			push_word(swr_pkg::KIND_DATA, data, delivered, '0, '0, 1'b0);
			run = 1;
			while (run < DEPTH && slot_vld[run]) begin
				push_word(swr_pkg::KIND_DATA, slot_dat[run], delivered + run, '0, '0, 1'b0);
				run++;
			end
			for (int i = 0; i < DEPTH; i++) begin
				if (i + run < DEPTH) begin
					slot_vld[i] = slot_vld[i + run];
					slot_dat[i] = slot_dat[i + run];
				end else begin
					slot_vld[i] = 1'b0;
					slot_dat[i] = '0;
				end
			end
			delivered += run;
			if (run > longest_run)
				longest_run = run;
			push_word(swr_pkg::KIND_ACK, '0, '0, delivered + 1, free_window(), 1'b1);
		end
	endfunction

	function automatic void check_field(string name, logic [swr_pkg::SEQ_W-1:0] want,
			logic [swr_pkg::SEQ_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void mix_order(ref int q[$]);
		int j;
		int t;
		for (int i = q.size() - 1; i > 0; i--) begin
			j    = $urandom_range(0, i);
			t    = q[i];
			q[i] = q[j];
			q[j] = t;
		end
	endfunction

	always @(posedge clk) begin : check_words
		rx_word_t want;
		if (arst_n && res.valid && res.ready) begin
			n_words++;
			if (due_words.size() == 0) begin
				$error("result word with none due: kind %0d byte 0x%0h ack 0x%0h",
					res.kind, res.out_byte, res.ack_next);
				fail_count++;
			end else begin
				want = due_words.pop_front();
				if (want.kind == swr_pkg::KIND_DATA)
					n_bytes++;
				else
					n_acks++;
				check_field("kind", swr_pkg::SEQ_W'(want.kind), swr_pkg::SEQ_W'(res.kind));
				check_field("out_byte", swr_pkg::SEQ_W'(want.out_byte),
					swr_pkg::SEQ_W'(res.out_byte));
				check_field("position", want.position, res.position);
				check_field("ack_next", want.ack_next, res.ack_next);
				check_field("adv_window", swr_pkg::SEQ_W'(want.adv_window),
					swr_pkg::SEQ_W'(res.adv_window));
				check_field("last", swr_pkg::SEQ_W'(want.last), swr_pkg::SEQ_W'(res.last));
			end
		end
	end

	// Receiver: a long hold-off when asked for, otherwise the pattern of the phase.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res.ready <= 1'b0;
			hold_left--;
		end else if (hold_req != 0) begin
			hold_left = hold_req - 1;
			hold_req  = 0;
			res.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: begin
					res.ready <= 1'b1;
				end
				RX_RANDOM: begin
					res.ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					if (rx_run == 0) begin
						rx_level = !rx_level;
						rx_run   = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 6);
					end
					rx_run--;
					res.ready <= rx_level;
				end
			endcase
		end
	end

	task automatic send_packet(logic [swr_pkg::SEQ_W-1:0] seq,
			logic [swr_pkg::BYTE_W-1:0] data, logic ok);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				pkt.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		pkt.valid     <= 1'b1;
		pkt.seq_num   <= seq;
		pkt.payload   <= data;
		pkt.packet_ok <= ok;
		@(posedge clk);
		while (!pkt.ready)
			@(posedge clk);
		receive_packet(seq, data, ok);
		burst_left--;
		n_sent++;
		if (ok)
			n_counted++;
	endtask

	// Dropped packets leave no word behind, so the task also waits out a settle period after the last one.
	task automatic wait_idle();
		int unsigned waited = 0;
		pkt.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [swr_pkg::APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {swr_pkg::REG_WINDOW, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		win_reg = value[swr_pkg::WIN_W-1:0];
		n_configs++;
	endtask

	task automatic set_pacing(int unsigned gaps, int unsigned bursts, rx_mode_t mode);
		gap_max    = gaps;
		burst_max  = bursts;
		rx_mode    = mode;
		burst_left = 0;
	endtask

	task automatic test_in_order_and_behind();
		set_pacing(2, 3, RX_RANDOM);
		send_packet(32'd1, 8'h00, 1'b1);
		send_packet(32'd2, 8'hFF, 1'b1);
		send_packet(32'd3, 8'hA5, 1'b0);
		send_packet(32'd1, 8'h11, 1'b1);
		send_packet(32'd0, 8'h22, 1'b1);
		send_packet(32'hFFFF_FFFF, 8'h33, 1'b1);
		// Offset of exactly half the sequence space counts as behind.
		send_packet(32'h8000_0003, 8'h44, 1'b1);
		send_packet(32'h8000_0002, 8'h55, 1'b1);
		send_packet(32'd35, 8'h66, 1'b1);
	endtask

	task automatic test_reorder_slots();
		set_pacing(0, 1, RX_BURSTY);
		send_packet(32'd5, 8'h5A, 1'b1);
		send_packet(32'd5, 8'hC3, 1'b1);
		send_packet(32'd34, 8'h34, 1'b1);
		send_packet(32'd4, 8'h04, 1'b1);
		send_packet(32'd3, 8'h03, 1'b1);
	endtask

	task automatic test_window_limits();
		set_pacing(1, 2, RX_FREE);
		wait_idle();
		write_window(32'd0);
		send_packet(delivered + 1, 8'h61, 1'b1);
		send_packet(32'd2, 8'h62, 1'b1);
		wait_idle();
		write_window(32'd2);
		send_packet(delivered + 1, 8'h63, 1'b1);
		send_packet(delivered + 2, 8'h64, 1'b1);
		send_packet(delivered + 3, 8'h65, 1'b1);
		wait_idle();
		write_window(32'hFFFF_FFC0 | 32'd63);
		send_packet(delivered + 1, 8'h66, 1'b1);
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_window(32'd32);
		set_pacing(0, 1, RX_FREE);
		hold_req = LONG_HOLD;
		repeat (20)
			send_packet(delivered + 1, 8'($urandom), 1'b1);
	endtask

	task automatic send_window_burst();
		int                        offs[$];
		int unsigned               k;
		int unsigned               r;
		logic [swr_pkg::SEQ_W-1:0] base;
		logic                      skip_head;
		k    = $urandom_range(1, live_window());
		base = delivered + 1;
		offs = {};
		for (int j = 0; j < k; j++)
			offs.push_back(j);
		mix_order(offs);
		skip_head = ($urandom_range(0, 9) == 0);
		foreach (offs[j]) begin
			if (!(skip_head && offs[j] == 0)) begin
				r = $urandom_range(0, 15);
				if (r == 0)
					send_packet(base + offs[j], 8'($urandom), 1'b0);
				send_packet(base + offs[j], 8'($urandom), 1'b1);
				if (r == 1)
					send_packet(base + offs[j], 8'($urandom), 1'b1);
			end
		end
	endtask

	task automatic send_noise();
		logic [swr_pkg::SEQ_W-1:0] seq;
		case ($urandom_range(0, 2))
			0: seq = $urandom;
			1: seq = delivered + 1 + $urandom_range(0, 40);
			default: seq = delivered + 1 - $urandom_range(1, 5);
		endcase
		send_packet(seq, 8'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(logic [swr_pkg::APB_DATA_W-1:0] window, int unsigned gaps,
			int unsigned bursts, rx_mode_t mode, int unsigned quota);
		int unsigned start;
		wait_idle();
		write_window(window);
		set_pacing(gaps, bursts, mode);
		start = n_counted;
		while (n_counted - start < quota) begin
			if ($urandom_range(0, 9) < 7)
				send_window_burst();
			else
				send_noise();
		end
	endtask

	// Fills every reorder slot behind the head in random order, then sends the head of the window.
	task automatic test_full_reorder_drain(int unsigned gaps, rx_mode_t mode);
		int                        offs[$];
		logic [swr_pkg::SEQ_W-1:0] base;
		wait_idle();
		write_window(32'd32);
		set_pacing(gaps, 6, mode);
		base = delivered + 1;
		offs = {};
		for (int j = 1; j < DEPTH; j++)
			offs.push_back(j);
		mix_order(offs);
		foreach (offs[j])
			send_packet(base + offs[j], 8'($urandom), 1'b1);
		send_packet(base, 8'($urandom), 1'b1);
	endtask

	task automatic test_random_windows();
		run_phase(32'd32, 0, 1, RX_FREE, 20);
		run_phase(32'd5, 4, 6, RX_RANDOM, 15);
		run_phase(32'd1, 2, 3, RX_BURSTY, 15);
		test_full_reorder_drain(3, RX_BURSTY);
		run_phase($urandom_range(2, 31), 6, 10, RX_BURSTY, 20);
		run_phase(32'd0, 3, 8, RX_RANDOM, 10);
		run_phase(32'({8'($urandom_range(0, 255)), 8'd63}), 0, 1, RX_BURSTY, 15);
		run_phase(32'd32, 5, 12, RX_RANDOM, 20);
		test_full_reorder_drain(0, RX_FREE);
	endtask

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		pkt.valid     = 1'b0;
		pkt.seq_num   = '0;
		pkt.payload   = '0;
		pkt.packet_ok = 1'b0;
		res.ready     = 1'b0;
		win_reg       = swr_pkg::WINDOW_RESET;
		delivered     = '0;
		foreach (slot_vld[i]) begin
			slot_vld[i] = 1'b0;
			slot_dat[i] = '0;
		end
		fail_count  = 0;
		n_sent      = 0;
		n_counted   = 0;
		n_configs   = 0;
		n_words     = 0;
		n_bytes     = 0;
		n_acks      = 0;
		longest_run = 0;
		hold_req    = 0;
		hold_left   = 0;
		rx_run      = 0;
		rx_level    = 1'b0;
		rx_mode     = RX_FREE;
		burst_left  = 0;
		gap_max     = 0;
		burst_max   = 1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_window(32'd32);

		test_in_order_and_behind();
		test_reorder_slots();
		test_window_limits();
		test_backpressure();
		test_random_windows();

		wait_idle();
		repeat (40) @(posedge clk);
		if (due_words.size() != 0) begin
			$error("%0d result words never arrived", due_words.size());
			fail_count++;
		end

		$display("Sent %0d packets (%0d with a good checksum) across %0d window writes.",
			n_sent, n_counted, n_configs);
		$display("Checked %0d words: %0d bytes, %0d acks; longest in-order run %0d bytes.",
			n_words, n_bytes, n_acks, longest_run);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
